// ===== src/ift_pkg.sv =====
// shared types and character codes for the field tokenizer
// no dependencies; imported by every module of the block
`default_nettype none

package ift_pkg;

  localparam int DEFAULT_MAX_FIELD_LEN = 1024;
  localparam int DEFAULT_QUEUE_DEPTH   = 2;

  localparam int CHAR_W = 32;
  localparam int LEN_W  = 11;

  localparam logic [CHAR_W-1:0] CH_COMMA = 32'h0000_002C;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 32'h0000_0022;
  localparam logic [CHAR_W-1:0] CH_CR    = 32'h0000_000D;
  localparam logic [CHAR_W-1:0] CH_LF    = 32'h0000_000A;
  localparam logic [CHAR_W-1:0] CH_TAB   = 32'h0000_0009;
  localparam logic [CHAR_W-1:0] CH_SPACE = 32'h0000_0020;

  // classified request handed from front to back
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              eoi;
    logic              is_blank;
    logic              is_comma;
    logic              is_quote;
    logic              is_cr;
    logic              is_lf;
    logic              is_str;
    logic [LEN_W-1:0]  max_len;
    logic              max_zero;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              char_valid;
    logic              field_end;
  } result_t;

  typedef enum logic [3:0] {
    PH_LEAD     = 4'b0001,
    PH_FIELD    = 4'b0010,
    PH_DELIM    = 4'b0100,
    PH_AFTER_CR = 4'b1000
  } phase_t;

endpackage

`default_nettype wire

// ===== src/ift_fifo.sv =====
// small first-in first-out queue of flip-flops, generic width and depth
// depends on ift_pkg for the default depth
`default_nettype none

module ift_fifo
  import ift_pkg::*;
#(
  parameter int WIDTH = 1,
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== src/ift_front.sv =====
// front end: decodes each incoming character into delimiter classes
// and clamps the requested field length; depends on ift_pkg
`default_nettype none

module ift_front
  import ift_pkg::*;
#(
  parameter int MAX_FIELD_LEN = DEFAULT_MAX_FIELD_LEN
) (
  input  wire logic [CHAR_W-1:0] in_char,
  input  wire logic              end_of_input,
  input  wire logic              field_is_string,
  input  wire logic [LEN_W-1:0]  field_max_len,
  output item_t                  item
);

  logic             live;
  logic [LEN_W-1:0] len_clamped;

  // end of input overrides every character class
  assign live = !end_of_input;

  always_comb begin
    if ({21'd0, field_max_len} > 32'(MAX_FIELD_LEN)) begin
      len_clamped = LEN_W'(MAX_FIELD_LEN);
    end else begin
      len_clamped = field_max_len;
    end
  end

  always_comb begin
    item.ch       = in_char;
    item.eoi      = end_of_input;
    item.is_blank = live && (in_char == CH_SPACE || in_char == CH_TAB);
    item.is_comma = live && (in_char == CH_COMMA);
    item.is_quote = live && (in_char == CH_QUOTE);
    item.is_cr    = live && (in_char == CH_CR);
    item.is_lf    = live && (in_char == CH_LF);
    item.is_str   = field_is_string;
    item.max_len  = len_clamped;
    item.max_zero = (len_clamped == '0);
  end

endmodule

`default_nettype wire

// ===== src/ift_back.sv =====
// back end: field state machine, one classified request per cycle while the result queue is not full
// depends on ift_pkg for item_t, result_t and phase_t
`default_nettype none

module ift_back
  import ift_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  input  wire item_t item,
  output logic       item_pop,
  input  wire logic  res_full,
  output logic       res_push,
  output result_t    res
);

  phase_t           phase;
  phase_t           phase_next;
  logic             in_quotes;
  logic             in_quotes_next;
  logic [LEN_W-1:0] field_length;
  logic [LEN_W-1:0] field_length_next;
  logic             lat_str;
  logic             lat_str_next;
  logic [LEN_W-1:0] lat_max;
  logic [LEN_W-1:0] lat_max_next;

  logic             take;
  logic             emit;
  logic             enter_lead;
  logic             run_field;
  logic             q_eff;
  logic             str_eff;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] max_eff;
  logic [LEN_W:0]   len_inc;

  assign take     = item_valid && !res_full;
  assign item_pop = take;
  assign res_push = take && emit;

  always_comb begin
    phase_next        = phase;
    in_quotes_next    = in_quotes;
    field_length_next = field_length;
    lat_str_next      = lat_str;
    lat_max_next      = lat_max;
    emit              = 1'b0;
    res               = '0;
    enter_lead        = 1'b0;
    run_field         = 1'b0;
    len_inc           = {1'b0, field_length} + 1'b1;

    unique case (phase)
      PH_FIELD: begin
        run_field = 1'b1;
      end
      PH_DELIM: begin
        if (item.eoi || item.is_comma || item.is_lf) begin
          phase_next = PH_LEAD;
        end else if (item.is_cr) begin
          phase_next = PH_AFTER_CR;
        end else if (!item.is_blank) begin
          enter_lead = 1'b1;
        end
      end
      PH_AFTER_CR: begin
        phase_next = PH_LEAD;
        if (!(item.eoi || item.is_lf)) begin
          enter_lead = 1'b1;
        end
      end
      default: begin
        enter_lead = 1'b1;
      end
    endcase

    // start of a new field: latch the per-field settings
    if (enter_lead) begin
      phase_next = PH_LEAD;
      if (!item.is_blank) begin
        lat_str_next      = item.is_str;
        lat_max_next      = item.max_len;
        field_length_next = '0;
        in_quotes_next    = 1'b0;
        if (item.eoi) begin
          emit          = 1'b1;
          res.field_end = 1'b1;
        end else if (item.max_zero) begin
          phase_next    = item.is_cr ? PH_AFTER_CR : PH_LEAD;
          emit          = 1'b1;
          res.field_end = 1'b1;
        end else begin
          phase_next = PH_FIELD;
          run_field  = 1'b1;
        end
      end
    end

    q_eff   = in_quotes_next;
    str_eff = lat_str_next;
    len_eff = field_length_next;
    max_eff = lat_max_next;
    len_inc = {1'b0, len_eff} + 1'b1;

    if (run_field) begin
      if (item.eoi || item.is_lf) begin
        phase_next    = PH_LEAD;
        emit          = 1'b1;
        res.field_end = 1'b1;
      end else if (item.is_cr) begin
        phase_next    = PH_AFTER_CR;
        emit          = 1'b1;
        res.field_end = 1'b1;
      end else if (item.is_quote && !(!q_eff && len_eff != '0)) begin
        // opening quote only before the first kept character
        in_quotes_next = !q_eff;
        if (q_eff && str_eff) begin
          phase_next    = PH_DELIM;
          emit          = 1'b1;
          res.field_end = 1'b1;
        end
      end else if (item.is_comma && !q_eff) begin
        phase_next    = PH_LEAD;
        emit          = 1'b1;
        res.field_end = 1'b1;
      end else if (item.is_blank && !q_eff && !str_eff) begin
        phase_next    = PH_DELIM;
        emit          = 1'b1;
        res.field_end = 1'b1;
      end else begin
        field_length_next = len_inc[LEN_W-1:0];
        emit              = 1'b1;
        res.out_char      = item.ch;
        res.char_valid    = 1'b1;
        if (len_inc >= {1'b0, max_eff}) begin
          phase_next    = PH_DELIM;
          res.field_end = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEAD;
      in_quotes    <= 1'b0;
      field_length <= '0;
      lat_str      <= 1'b0;
      lat_max      <= '0;
    end else if (take) begin
      phase        <= phase_next;
      in_quotes    <= in_quotes_next;
      field_length <= field_length_next;
      lat_str      <= lat_str_next;
      lat_max      <= lat_max_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/input_field_tokenizer.sv =====
// Field tokenizer for a stream of 32-bit characters.
// Input channel: drive in_char, end_of_input, field_is_string and
// field_max_len with push; a request is taken at a clock edge with push high
// and full low. field_is_string and field_max_len matter only on the request
// that starts a field; field_max_len is limited to MAX_FIELD_LEN.
// Result channel: while empty is low the oldest result sits on out_char,
// char_valid and field_end; it is taken at an edge with pop high.
// Each field gives one result per kept character, and ends with either a
// result carrying char_valid 0 and field_end 1, or, when cut at its length
// limit, with field_end set on its last character. Leading blanks, opening
// quotes and swallowed delimiters give no result.
// Path: a taken request is registered in the request queue, its result in the result queue.
// Throughput: one request per cycle; the back end updates its field state for
// each request that it takes, so only pop stalls slow the block down.
// Stall: when pop stays low the result queue fills, then the request queue
// between front and back (QUEUE_DEPTH entries) fills and full rises.
// Reset (rst, synchronous): both queues empty, next request starts a field.
// Structure: front end classifies, request queue, back end state machine,
// result queue.
`default_nettype none

module input_field_tokenizer
  import ift_pkg::*;
#(
  parameter int MAX_FIELD_LEN = DEFAULT_MAX_FIELD_LEN,
  parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [CHAR_W-1:0] in_char,
  input  wire logic              end_of_input,
  input  wire logic              field_is_string,
  input  wire logic [LEN_W-1:0]  field_max_len,
  output logic                   empty,
  input  wire logic              pop,
  output logic [CHAR_W-1:0]      out_char,
  output logic                   char_valid,
  output logic                   field_end
);

  item_t   front_item;
  item_t   back_item;
  logic    item_empty;
  logic    item_pop;
  logic    res_full;
  logic    res_push;
  result_t back_res;
  result_t head_res;

  ift_front #(
    .MAX_FIELD_LEN(MAX_FIELD_LEN)
  ) u_front (
    .in_char        (in_char),
    .end_of_input   (end_of_input),
    .field_is_string(field_is_string),
    .field_max_len  (field_max_len),
    .item           (front_item)
  );

  ift_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_item_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(front_item),
    .full (full),
    .pop  (item_pop),
    .rdata(back_item),
    .empty(item_empty)
  );

  ift_back u_back (
    .clk       (clk),
    .rst       (rst),
    .item_valid(!item_empty),
    .item      (back_item),
    .item_pop  (item_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  ift_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(back_res),
    .full (res_full),
    .pop  (pop),
    .rdata(head_res),
    .empty(empty)
  );

  assign out_char   = head_res.out_char;
  assign char_valid = head_res.char_valid;
  assign field_end  = head_res.field_end;

endmodule

`default_nettype wire

// ===== src/ift_checker.sv =====
// port-level checks for input_field_tokenizer, attached by bind
// depends on ift_pkg for widths
`default_nettype none

module ift_checker
  import ift_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              push,
  input wire logic              full,
  input wire logic              empty,
  input wire logic              pop,
  input wire logic [CHAR_W-1:0] out_char,
  input wire logic              char_valid,
  input wire logic              field_end
);

  // reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // a result without a character always closes a field
  a_bare_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && !char_valid) |-> field_end)
    else $error("result without character does not end a field");

  // a result without a character carries a zero character
  a_bare_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !char_valid) |-> (out_char == '0))
    else $error("nonzero character on a bare field end");

  // no result can appear in the cycle after an idle, empty block
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    (empty && full == 1'b0 && !push && $past(!push)) |=> empty || $past(!empty, 2)
      || $past(push, 2) || $past(full, 2))
    else $error("result appeared without a request");

  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(char_valid)
      && $stable(field_end)))
    else $error("waiting result changed before pop");

endmodule

bind input_field_tokenizer ift_checker u_ift_checker (.*);

`default_nettype wire
